// File: sv/grid_block_decomposition_3d_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3D grid block decomposition
// Shared implication forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef GRID_BLOCK_DECOMPOSITION_3D_ASSERT_SVH
`define GRID_BLOCK_DECOMPOSITION_3D_ASSERT_SVH

// same-cycle implication
`define GBD_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("gbd assertion failed (same cycle)");

// next-cycle implication
`define GBD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("gbd assertion failed (next cycle)");

`endif

// File: sv/gbd_pkg.sv
// ----------------------------------------------------------------------------
// gbd_pkg
// Widths, register codes and reciprocal table for the grid block decomposition.
// ----------------------------------------------------------------------------
package gbd_pkg;

	localparam int RANK_W   = 12;
	localparam int DENS_W   = 4;
	localparam int NODES_W  = 5;
	localparam int POINTS_W = 11;
	localparam int OUT_W    = 14;
	localparam int COORD_W  = 4;

	localparam int MAX_NODES_PER_AXIS  = 16;
	localparam int MAX_POINTS_PER_AXIS = 1024;
	localparam int MAX_DENSITY         = 8;

	// reciprocal divide: q = (n * ceil(2^16 / p)) >> 16, exact for n < 4096, p <= 16
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = RANK_W + RECIP_W;

	localparam int NSTAGE  = 9;
	localparam int NAXIS   = 3;
	localparam int AX_X    = 0;
	localparam int AX_Y    = 1;
	localparam int AX_Z    = 2;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = POINTS_W;
	localparam logic [CFG_IDX_W-1:0] CFG_NODES_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODES_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODES_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Z = 3'd5;

	typedef struct packed {
		logic [NSTAGE-1:0] load;
		logic [NSTAGE-1:0] valid;
	} gbd_ctl_t;

	function automatic logic [NODES_W-1:0] eff_nodes(input logic [NODES_W-1:0] n);
		logic [NODES_W-1:0] r;
		if (n == '0) begin
			r = NODES_W'(1);
		end else if (n > NODES_W'(MAX_NODES_PER_AXIS)) begin
			r = NODES_W'(MAX_NODES_PER_AXIS);
		end else begin
			r = n;
		end
		return r;
	endfunction

	function automatic logic [POINTS_W-1:0] eff_points(input logic [POINTS_W-1:0] n);
		logic [POINTS_W-1:0] r;
		if (n > POINTS_W'(MAX_POINTS_PER_AXIS)) begin
			r = POINTS_W'(MAX_POINTS_PER_AXIS);
		end else begin
			r = n;
		end
		return r;
	endfunction

	// ceil(2^16 / p) for p in 1..16
	function automatic logic [RECIP_W-1:0] recip(input logic [NODES_W-1:0] p);
		logic [RECIP_W-1:0] m;
		case (p)
			5'd1:    m = 17'd65536;
			5'd2:    m = 17'd32768;
			5'd3:    m = 17'd21846;
			5'd4:    m = 17'd16384;
			5'd5:    m = 17'd13108;
			5'd6:    m = 17'd10923;
			5'd7:    m = 17'd9363;
			5'd8:    m = 17'd8192;
			5'd9:    m = 17'd7282;
			5'd10:   m = 17'd6554;
			5'd11:   m = 17'd5958;
			5'd12:   m = 17'd5462;
			5'd13:   m = 17'd5042;
			5'd14:   m = 17'd4682;
			5'd15:   m = 17'd4370;
			5'd16:   m = 17'd4096;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

// File: sv/gbd_div.sv
// ----------------------------------------------------------------------------
// gbd_div
// Two-stage divide of a 12-bit word by a node count of 1..16 via reciprocal.
// ----------------------------------------------------------------------------
module gbd_div (
	input  logic                          clk,
	input  logic [1:0]                    load,
	input  logic [gbd_pkg::RANK_W-1:0]    num,
	input  logic [gbd_pkg::NODES_W-1:0]   den,
	output logic [gbd_pkg::RANK_W-1:0]    quo,
	output logic [gbd_pkg::COORD_W-1:0]   rem
);

	logic [gbd_pkg::PROD_W-1:0] prod_s1;
	logic [gbd_pkg::RANK_W-1:0] num_s1;
	logic [gbd_pkg::RANK_W-1:0] quo_c;
	logic [gbd_pkg::RANK_W-1:0] back_c;
	logic [gbd_pkg::RANK_W-1:0] rem_c;
	logic [gbd_pkg::RANK_W-1:0] quo_s2;
	logic [gbd_pkg::COORD_W-1:0] rem_s2;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			prod_s1 <= gbd_pkg::PROD_W'(num) * gbd_pkg::PROD_W'(gbd_pkg::recip(den));
			num_s1  <= num;
		end
	end

	// quotient never exceeds the dividend, so the back product fits 12 bits
	always_comb begin
		quo_c  = prod_s1[gbd_pkg::RECIP_SHIFT +: gbd_pkg::RANK_W];
		back_c = quo_c * gbd_pkg::RANK_W'(den);
		rem_c  = num_s1 - back_c;
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			quo_s2 <= quo_c;
			rem_s2 <= rem_c[gbd_pkg::COORD_W-1:0];
		end
	end

	assign quo = quo_s2;
	assign rem = rem_s2;

endmodule

// File: sv/gbd_pipe_ctl.sv
// ----------------------------------------------------------------------------
// gbd_pipe_ctl
// Valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module gbd_pipe_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              result_stall,
	output gbd_pkg::gbd_ctl_t ctl
);

	logic [gbd_pkg::NSTAGE-1:0] valid_q;
	logic [gbd_pkg::NSTAGE-1:0] ready;

	// a stage may load when it is empty or its word moves on
	always_comb begin
		ready[gbd_pkg::NSTAGE-1] = !valid_q[gbd_pkg::NSTAGE-1] || !result_stall;
		for (int k = gbd_pkg::NSTAGE - 2; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) begin
				valid_q[0] <= item_valid;
			end
			for (int k = 1; k < gbd_pkg::NSTAGE; k++) begin
				if (ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctl.load  = ready;
	assign ctl.valid = valid_q;

endmodule

// File: sv/grid_block_decomposition_3d.sv
// ----------------------------------------------------------------------------
// grid_block_decomposition_3d
// Nine register stages, s1 to s9; result_valid is the valid bit of stage s9.
// Stalls hold only full stages.
// Throughput: one word per cycle while result_stall does not back up to s1; the
// three chained reciprocal divides and the offset multiply each take their own stages.
// Reset clears config registers to 1 and empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
`include "grid_block_decomposition_3d_assert.svh"

module grid_block_decomposition_3d (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// item channel
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [gbd_pkg::RANK_W-1:0]         rank,
	input  logic [gbd_pkg::DENS_W-1:0]         density,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [gbd_pkg::RANK_W-1:0]         north_rank,
	output logic [gbd_pkg::RANK_W-1:0]         south_rank,
	output logic [gbd_pkg::RANK_W-1:0]         east_rank,
	output logic [gbd_pkg::RANK_W-1:0]         west_rank,
	output logic [gbd_pkg::RANK_W-1:0]         up_rank,
	output logic [gbd_pkg::RANK_W-1:0]         down_rank,
	output logic [gbd_pkg::OUT_W-1:0]          size_x,
	output logic [gbd_pkg::OUT_W-1:0]          size_y,
	output logic [gbd_pkg::OUT_W-1:0]          size_z,
	output logic [gbd_pkg::OUT_W-1:0]          offset_x,
	output logic [gbd_pkg::OUT_W-1:0]          offset_y,
	output logic [gbd_pkg::OUT_W-1:0]          offset_z
);

	localparam int CQ_W  = gbd_pkg::RANK_W + gbd_pkg::POINTS_W;   // coord * quotient
	localparam int PRE_W = CQ_W + 1;
	localparam int SAT_W = PRE_W + gbd_pkg::DENS_W;
	localparam int SZ_W  = gbd_pkg::POINTS_W + gbd_pkg::DENS_W;
	localparam int PYZ_W = 2 * gbd_pkg::NODES_W;

	// words carried along the early stages
	typedef struct packed {
		logic [gbd_pkg::DENS_W-1:0]                       d;
		logic [gbd_pkg::COORD_W-1:0]                      z;
		logic [gbd_pkg::NAXIS-1:0][gbd_pkg::POINTS_W-1:0] q;   // N / P per axis
		logic [gbd_pkg::NAXIS-1:0][gbd_pkg::COORD_W-1:0]  r;   // N % P per axis
	} gbd_carry_t;

	// saturate to the 14-bit result range
	function automatic logic [gbd_pkg::OUT_W-1:0] sat14(input logic [SAT_W-1:0] v);
		logic [gbd_pkg::OUT_W-1:0] r;
		if (v > SAT_W'(gbd_pkg::OUT_MAX)) begin
			r = gbd_pkg::OUT_MAX;
		end else begin
			r = v[gbd_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	// torus step up/down on a coordinate already below p
	function automatic logic [gbd_pkg::COORD_W-1:0] wrap_up(
		input logic [gbd_pkg::COORD_W-1:0] c,
		input logic [gbd_pkg::NODES_W-1:0] p
	);
		logic [gbd_pkg::NODES_W-1:0] n;
		n = gbd_pkg::NODES_W'(c) + gbd_pkg::NODES_W'(1);
		return (n == p) ? '0 : n[gbd_pkg::COORD_W-1:0];
	endfunction

	function automatic logic [gbd_pkg::COORD_W-1:0] wrap_dn(
		input logic [gbd_pkg::COORD_W-1:0] c,
		input logic [gbd_pkg::NODES_W-1:0] p
	);
		logic [gbd_pkg::NODES_W-1:0] n;
		if (c == '0) begin
			n = p - gbd_pkg::NODES_W'(1);
		end else begin
			n = gbd_pkg::NODES_W'(c) - gbd_pkg::NODES_W'(1);
		end
		return n[gbd_pkg::COORD_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// configuration registers (always ready; the user must write them only while idle; not enforced here)
	// ------------------------------------------------------------------
	logic [gbd_pkg::NODES_W-1:0]  nodes_x_q, nodes_y_q, nodes_z_q;
	logic [gbd_pkg::POINTS_W-1:0] points_x_q, points_y_q, points_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_x_q  <= gbd_pkg::NODES_W'(1);
			nodes_y_q  <= gbd_pkg::NODES_W'(1);
			nodes_z_q  <= gbd_pkg::NODES_W'(1);
			points_x_q <= gbd_pkg::POINTS_W'(1);
			points_y_q <= gbd_pkg::POINTS_W'(1);
			points_z_q <= gbd_pkg::POINTS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gbd_pkg::CFG_NODES_X:  nodes_x_q  <= cfg_data[gbd_pkg::NODES_W-1:0];
				gbd_pkg::CFG_NODES_Y:  nodes_y_q  <= cfg_data[gbd_pkg::NODES_W-1:0];
				gbd_pkg::CFG_NODES_Z:  nodes_z_q  <= cfg_data[gbd_pkg::NODES_W-1:0];
				gbd_pkg::CFG_POINTS_X: points_x_q <= cfg_data;
				gbd_pkg::CFG_POINTS_Y: points_y_q <= cfg_data;
				gbd_pkg::CFG_POINTS_Z: points_z_q <= cfg_data;
				default: ;   // unknown index: dropped
			endcase
		end
	end

	// clamped counts; the user must keep them stable while any word is in flight (not enforced)
	logic [gbd_pkg::NODES_W-1:0]                       px, py, pz;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::NODES_W-1:0]   pa;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::POINTS_W-1:0]  na;
	logic [PYZ_W-1:0]                                  pyz;

	always_comb begin
		px = gbd_pkg::eff_nodes(nodes_x_q);
		py = gbd_pkg::eff_nodes(nodes_y_q);
		pz = gbd_pkg::eff_nodes(nodes_z_q);
		pa[gbd_pkg::AX_X] = px;
		pa[gbd_pkg::AX_Y] = py;
		pa[gbd_pkg::AX_Z] = pz;
		na[gbd_pkg::AX_X] = gbd_pkg::eff_points(points_x_q);
		na[gbd_pkg::AX_Y] = gbd_pkg::eff_points(points_y_q);
		na[gbd_pkg::AX_Z] = gbd_pkg::eff_points(points_z_q);
		pyz = PYZ_W'(py) * PYZ_W'(pz);
	end

	// ------------------------------------------------------------------
	// pipeline control
	// ------------------------------------------------------------------
	gbd_pkg::gbd_ctl_t ctl;

	gbd_pipe_ctl u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.result_stall (result_stall),
		.ctl          (ctl)
	);

	assign item_stall   = !ctl.load[0];
	assign result_valid = ctl.valid[gbd_pkg::NSTAGE-1];

	// ------------------------------------------------------------------
	// s1/s2: rank / pz -> t, z ; N / P per axis
	// ------------------------------------------------------------------
	logic [gbd_pkg::DENS_W-1:0] d_s1, d_s2;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			d_s1 <= (density > gbd_pkg::DENS_W'(gbd_pkg::MAX_DENSITY))
				? gbd_pkg::DENS_W'(gbd_pkg::MAX_DENSITY) : density;
		end
		if (ctl.load[1]) begin
			d_s2 <= d_s1;
		end
	end

	logic [gbd_pkg::RANK_W-1:0]                       t_s2;
	logic [gbd_pkg::COORD_W-1:0]                      z_s2;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::RANK_W-1:0]   nq_s2;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::COORD_W-1:0]  nr_s2;

	gbd_div u_div_t (
		.clk  (clk),
		.load (ctl.load[1:0]),
		.num  (rank),
		.den  (pz),
		.quo  (t_s2),
		.rem  (z_s2)
	);

	for (genvar a = 0; a < gbd_pkg::NAXIS; a++) begin : g_axis_div
		gbd_div u_div_n (
			.clk  (clk),
			.load (ctl.load[1:0]),
			.num  (gbd_pkg::RANK_W'(na[a])),
			.den  (pa[a]),
			.quo  (nq_s2[a]),
			.rem  (nr_s2[a])
		);
	end

	// ------------------------------------------------------------------
	// s3/s4: t / py -> x (unreduced), y
	// ------------------------------------------------------------------
	gbd_carry_t cb_in, cb_s3, cb_s4, cb_s5;

	always_comb begin
		cb_in.d = d_s2;
		cb_in.z = z_s2;
		for (int a = 0; a < gbd_pkg::NAXIS; a++) begin
			cb_in.q[a] = nq_s2[a][gbd_pkg::POINTS_W-1:0];   // at most 1024
			cb_in.r[a] = nr_s2[a];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			cb_s3 <= cb_in;
		end
		if (ctl.load[3]) begin
			cb_s4 <= cb_s3;
		end
	end

	logic [gbd_pkg::RANK_W-1:0]  x_s4;
	logic [gbd_pkg::COORD_W-1:0] y_s4;

	gbd_div u_div_y (
		.clk  (clk),
		.load (ctl.load[3:2]),
		.num  (t_s2),
		.den  (py),
		.quo  (x_s4),
		.rem  (y_s4)
	);

	// ------------------------------------------------------------------
	// s5: reduce x twice, neighbor coords on y and z, size terms
	// x % px for east/west runs in parallel over s5/s6
	// ------------------------------------------------------------------
	logic [gbd_pkg::RANK_W-1:0]                       x1_c, xr_c;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::RANK_W-1:0]   c4_c;
	logic [gbd_pkg::NAXIS-1:0]                        inc_c;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::COORD_W-1:0]  mn_c;

	always_comb begin
		x1_c = (x_s4 >= gbd_pkg::RANK_W'(px)) ? x_s4 - gbd_pkg::RANK_W'(px) : x_s4;
		xr_c = (x1_c >= gbd_pkg::RANK_W'(px)) ? x1_c - gbd_pkg::RANK_W'(px) : x1_c;
		c4_c[gbd_pkg::AX_X] = xr_c;
		c4_c[gbd_pkg::AX_Y] = gbd_pkg::RANK_W'(y_s4);
		c4_c[gbd_pkg::AX_Z] = gbd_pkg::RANK_W'(cb_s4.z);
		for (int a = 0; a < gbd_pkg::NAXIS; a++) begin
			inc_c[a] = c4_c[a] < gbd_pkg::RANK_W'(cb_s4.r[a]);
			mn_c[a]  = inc_c[a] ? c4_c[a][gbd_pkg::COORD_W-1:0] : cb_s4.r[a];
		end
	end

	logic [gbd_pkg::RANK_W-1:0]                       xr_s5;
	logic [gbd_pkg::COORD_W-1:0]                      y_s5, yn_s5, ys_s5, zu_s5, zd_s5;
	logic [gbd_pkg::NAXIS-1:0]                        inc_s5;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::COORD_W-1:0]  mn_s5;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			cb_s5  <= cb_s4;
			xr_s5  <= xr_c;
			y_s5   <= y_s4;
			yn_s5  <= wrap_up(y_s4, py);
			ys_s5  <= wrap_dn(y_s4, py);
			zu_s5  <= wrap_up(cb_s4.z, pz);
			zd_s5  <= wrap_dn(cb_s4.z, pz);
			inc_s5 <= inc_c;
			mn_s5  <= mn_c;
		end
	end

	logic [gbd_pkg::COORD_W-1:0] xm_s6;   // x mod px

	gbd_div u_div_x (
		.clk  (clk),
		.load (ctl.load[5:4]),
		.num  (x_s4),
		.den  (px),
		.quo  (),
		.rem  (xm_s6)
	);

	// ------------------------------------------------------------------
	// s6: sizes, coord*quotient, rank partial products (mod 4096)
	// ------------------------------------------------------------------
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::RANK_W-1:0]    c5_c;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::POINTS_W-1:0]  qinc_c;
	logic [gbd_pkg::NAXIS-1:0][SZ_W-1:0]               szp_c;

	always_comb begin
		c5_c[gbd_pkg::AX_X] = xr_s5;
		c5_c[gbd_pkg::AX_Y] = gbd_pkg::RANK_W'(y_s5);
		c5_c[gbd_pkg::AX_Z] = gbd_pkg::RANK_W'(cb_s5.z);
		for (int a = 0; a < gbd_pkg::NAXIS; a++) begin
			qinc_c[a] = cb_s5.q[a] + gbd_pkg::POINTS_W'(inc_s5[a]);
			szp_c[a]  = SZ_W'(cb_s5.d) * SZ_W'(qinc_c[a]);
		end
	end

	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::OUT_W-1:0]     size_s6, size_s7, size_s8, size_s9;
	logic [gbd_pkg::NAXIS-1:0][CQ_W-1:0]               cq_s6;
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::COORD_W-1:0]   mn_s6;
	logic [gbd_pkg::RANK_W-1:0]                        xrp_s6, yp_s6, ynp_s6, ysp_s6;
	logic [gbd_pkg::COORD_W-1:0]                       z_s6, zu_s6, zd_s6;
	logic [gbd_pkg::DENS_W-1:0]                        d_s6;

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			for (int a = 0; a < gbd_pkg::NAXIS; a++) begin
				size_s6[a] <= sat14(SAT_W'(szp_c[a]));
				cq_s6[a]   <= CQ_W'(c5_c[a]) * CQ_W'(cb_s5.q[a]);
			end
			mn_s6  <= mn_s5;
			xrp_s6 <= xr_s5 * gbd_pkg::RANK_W'(pyz);
			yp_s6  <= gbd_pkg::RANK_W'(y_s5) * gbd_pkg::RANK_W'(pz);
			ynp_s6 <= gbd_pkg::RANK_W'(yn_s5) * gbd_pkg::RANK_W'(pz);
			ysp_s6 <= gbd_pkg::RANK_W'(ys_s5) * gbd_pkg::RANK_W'(pz);
			z_s6   <= cb_s5.z;
			zu_s6  <= zu_s5;
			zd_s6  <= zd_s5;
			d_s6   <= cb_s5.d;
		end
	end

	// ------------------------------------------------------------------
	// s7: east/west x coords, offset pre-sum
	// ------------------------------------------------------------------
	logic [gbd_pkg::COORD_W-1:0]                xe_s7, xw_s7, z_s7, zu_s7, zd_s7;
	logic [gbd_pkg::NAXIS-1:0][PRE_W-1:0]       pre_s7;
	logic [gbd_pkg::RANK_W-1:0]                 xrp_s7, yp_s7, ynp_s7, ysp_s7;
	logic [gbd_pkg::DENS_W-1:0]                 d_s7;

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			xe_s7 <= wrap_up(xm_s6, px);
			xw_s7 <= wrap_dn(xm_s6, px);
			for (int a = 0; a < gbd_pkg::NAXIS; a++) begin
				pre_s7[a] <= PRE_W'(cq_s6[a]) + PRE_W'(mn_s6[a]);
			end
			size_s7 <= size_s6;
			xrp_s7  <= xrp_s6;
			yp_s7   <= yp_s6;
			ynp_s7  <= ynp_s6;
			ysp_s7  <= ysp_s6;
			z_s7    <= z_s6;
			zu_s7   <= zu_s6;
			zd_s7   <= zd_s6;
			d_s7    <= d_s6;
		end
	end

	// ------------------------------------------------------------------
	// s8: offsets, four ranks that keep x, east/west x products
	// ------------------------------------------------------------------
	logic [gbd_pkg::NAXIS-1:0][gbd_pkg::OUT_W-1:0]  off_s8, off_s9;
	logic [gbd_pkg::RANK_W-1:0]  xep_s8, xwp_s8, yp_s8;
	logic [gbd_pkg::RANK_W-1:0]  north_s8, south_s8, up_s8, down_s8;
	logic [gbd_pkg::COORD_W-1:0] z_s8;

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			for (int a = 0; a < gbd_pkg::NAXIS; a++) begin
				off_s8[a] <= sat14(SAT_W'(d_s7) * SAT_W'(pre_s7[a]));
			end
			xep_s8   <= gbd_pkg::RANK_W'(xe_s7) * gbd_pkg::RANK_W'(pyz);
			xwp_s8   <= gbd_pkg::RANK_W'(xw_s7) * gbd_pkg::RANK_W'(pyz);
			north_s8 <= xrp_s7 + ynp_s7 + gbd_pkg::RANK_W'(z_s7);
			south_s8 <= xrp_s7 + ysp_s7 + gbd_pkg::RANK_W'(z_s7);
			up_s8    <= xrp_s7 + yp_s7 + gbd_pkg::RANK_W'(zu_s7);
			down_s8  <= xrp_s7 + yp_s7 + gbd_pkg::RANK_W'(zd_s7);
			yp_s8    <= yp_s7;
			z_s8     <= z_s7;
			size_s8  <= size_s7;
		end
	end

	// ------------------------------------------------------------------
	// s9: output register
	// ------------------------------------------------------------------
	logic [gbd_pkg::RANK_W-1:0] north_s9, south_s9, east_s9, west_s9, up_s9, down_s9;

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			east_s9  <= xep_s8 + yp_s8 + gbd_pkg::RANK_W'(z_s8);
			west_s9  <= xwp_s8 + yp_s8 + gbd_pkg::RANK_W'(z_s8);
			north_s9 <= north_s8;
			south_s9 <= south_s8;
			up_s9    <= up_s8;
			down_s9  <= down_s8;
			size_s9  <= size_s8;
			off_s9   <= off_s8;
		end
	end

	assign north_rank = north_s9;
	assign south_rank = south_s9;
	assign east_rank  = east_s9;
	assign west_rank  = west_s9;
	assign up_rank    = up_s9;
	assign down_rank  = down_s9;
	assign size_x     = size_s9[gbd_pkg::AX_X];
	assign size_y     = size_s9[gbd_pkg::AX_Y];
	assign size_z     = size_s9[gbd_pkg::AX_Z];
	assign offset_x   = off_s9[gbd_pkg::AX_X];
	assign offset_y   = off_s9[gbd_pkg::AX_Y];
	assign offset_z   = off_s9[gbd_pkg::AX_Z];

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`GBD_ASSERT_IMPL(a_room_no_stall, clk, arst_n, !result_valid, !item_stall)
	`GBD_ASSERT_NEXT(a_accept_enters, clk, arst_n, item_valid && !item_stall, ctl.valid[0])
	`GBD_ASSERT_IMPL(a_z_below_pz, clk, arst_n, ctl.valid[1], gbd_pkg::NODES_W'(z_s2) < pz)
	`GBD_ASSERT_IMPL(a_y_below_py, clk, arst_n, ctl.valid[3], gbd_pkg::NODES_W'(y_s4) < py)
	`GBD_ASSERT_IMPL(a_xm_below_px, clk, arst_n, ctl.valid[5], gbd_pkg::NODES_W'(xm_s6) < px)

endmodule
